// ===== hw/rtl/gtg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_pkg: shared types and constants of the go-to-goal PI controller
// Fixed point formats, status codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gtg_pkg;

  // Number formats
  localparam int FRAC_BITS  = 12;
  localparam int MOVE_TICKS = 100;
  localparam int TICK_RATE  = 20;

  localparam int POS_W   = 16;
  localparam int HEAD_W  = 16;
  localparam int SPD_W   = 20;
  localparam int TURN_W  = 16;
  localparam int STAT_W  = 2;
  localparam int GAIN_W  = 16;
  localparam int SUM_W   = 32;
  localparam int TICK_W  = 7;
  localparam int DIFF_W  = POS_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int DIST_W  = DIFF_W;
  localparam int NUM_W   = 22;
  localparam int CRD_W   = 28;
  localparam int CANG_W  = 21;
  localparam int ANG_W   = 18;
  localparam int MA_W    = 17;
  localparam int MB_W    = 33;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int TERM_W  = PROD_W - FRAC_BITS;
  localparam int ACC_W   = TERM_W + 2;
  localparam int ERR_W   = SPD_W + 1;
  localparam int CRD_STEPS  = 16;
  localparam int CRD_SCALE  = 8;
  localparam int CRD_FRAC   = 16;
  localparam int ANG_SH     = CRD_FRAC - FRAC_BITS;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int CNT_W      = 5;

  localparam logic signed [ANG_W-1:0]  PI_Q     = 18'sd12868;
  localparam logic signed [ANG_W-1:0]  TWO_PI_Q = 18'sd25736;
  localparam logic signed [CANG_W-1:0] PI_Q16   = 21'sd205887;
  localparam logic [DIST_W-1:0]        ARRIVE_Q = 17'd410;
  localparam logic signed [ACC_W-1:0]  SPD_MAX  = ACC_W'(524287);
  localparam logic signed [ACC_W-1:0]  SPD_MIN  = -ACC_W'(524288);
  localparam logic signed [SUM_W:0]    SUM_MAX  = 33'sh0_7FFF_FFFF;
  localparam logic signed [SUM_W:0]    SUM_MIN  = -33'sh0_8000_0000;
  localparam logic [GAIN_W-1:0]        GAIN_RST = 16'd819;

  // Configuration register indexes
  localparam logic CFG_PROP_GAIN = 1'b0;
  localparam logic CFG_INT_GAIN  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_MOVING, ST_ARRIVED, ST_ABORTED, ST_IDLE
  } status_e;

  typedef enum logic [1:0] {
    MUL_SQX, MUL_SQY, MUL_PROP, MUL_INT
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SQY, S_ADD, S_ROOT, S_CHK, S_DIV,
    S_MULP, S_MULI, S_UPD, S_OUT
  } state_e;

  typedef struct packed {
    logic     capture;
    logic     load_goal;
    logic     start_crd;
    logic     hold_sq;
    logic     start_sqrt;
    logic     start_div;
    mul_sel_e mul_sel;
    logic     upd_sum;
    logic     hold_p;
    logic     upd_move;
    logic     clr_active;
    logic     set_res;
    logic     res_move;
    status_e  res_status;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic op_start;
    logic active;
    logic root_busy;
    logic arrived;
    logic stop;
    logic div_busy;
    logic out_free;
  } sts_t;

  // atan(2^-i) in Q.16, rounded
  function automatic logic signed [CANG_W-1:0] atan_q16(input logic [3:0] i);
    logic signed [CANG_W-1:0] v;
    case (i)
      4'd0:    v = 21'sd51472;
      4'd1:    v = 21'sd30385;
      4'd2:    v = 21'sd16055;
      4'd3:    v = 21'sd8150;
      4'd4:    v = 21'sd4091;
      4'd5:    v = 21'sd2047;
      4'd6:    v = 21'sd1024;
      4'd7:    v = 21'sd512;
      4'd8:    v = 21'sd256;
      4'd9:    v = 21'sd128;
      4'd10:   v = 21'sd64;
      4'd11:   v = 21'sd32;
      4'd12:   v = 21'sd16;
      4'd13:   v = 21'sd8;
      4'd14:   v = 21'sd4;
      4'd15:   v = 21'sd2;
      default: v = 21'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gtg_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_ctrl: sequencing state machine
// Accepts one request at a time and steps the datapath through distance,
// bearing, division, PI update and result hand-off.
// ----------------------------------------------------------------------------
module gtg_ctrl
  import gtg_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul_sel    = MUL_SQX;
    cmd_o.res_status = ST_MOVING;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.op_start) begin
          cmd_o.load_goal  = 1'b1;
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_MOVING;
          state_d = S_OUT;
        end else if (!sts_i.active) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_IDLE;
          state_d = S_OUT;
        end else begin
          cmd_o.mul_sel   = MUL_SQX;
          cmd_o.start_crd = 1'b1;
          state_d = S_SQY;
        end
      end
      S_SQY: begin
        cmd_o.mul_sel = MUL_SQY;
        cmd_o.hold_sq = 1'b1;
        state_d = S_ADD;
      end
      S_ADD: begin
        cmd_o.start_sqrt = 1'b1;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (!sts_i.root_busy) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        // Arrival wins over a stop request
        if (sts_i.arrived) begin
          cmd_o.clr_active = 1'b1;
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_ARRIVED;
          state_d = S_OUT;
        end else if (sts_i.stop) begin
          cmd_o.clr_active = 1'b1;
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = ST_ABORTED;
          state_d = S_OUT;
        end else begin
          cmd_o.start_div = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = S_MULP;
        end
      end
      S_MULP: begin
        cmd_o.mul_sel = MUL_PROP;
        cmd_o.upd_sum = 1'b1;
        state_d = S_MULI;
      end
      S_MULI: begin
        cmd_o.mul_sel = MUL_INT;
        cmd_o.hold_p  = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd_move   = 1'b1;
        cmd_o.set_res    = 1'b1;
        cmd_o.res_move   = 1'b1;
        cmd_o.res_status = ST_MOVING;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Decisions are taken only once both iterative units have settled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> !sts_i.root_busy)
    else $error("decision taken while root or bearing unit busy");

endmodule
`default_nettype wire

// ===== hw/rtl/gtg_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_dp: controller datapath
// Holds the move state and gains, and contains the shared multiplier, the
// bit-pair square root, the restoring divider, the bearing CORDIC and the
// output register.
// ----------------------------------------------------------------------------
module gtg_dp
  import gtg_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_idx_i,
  input  wire logic [GAIN_W-1:0]        cfg_data_i,
  input  wire logic                     op_i,
  input  wire logic [POS_W-1:0]         goal_x_i,
  input  wire logic [POS_W-1:0]         goal_y_i,
  input  wire logic [POS_W-1:0]         pos_x_i,
  input  wire logic [POS_W-1:0]         pos_y_i,
  input  wire logic signed [HEAD_W-1:0] heading_i,
  input  wire logic                     stop_request_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [SPD_W-1:0]       linear_speed_o,
  output logic signed [TURN_W-1:0]      turn_rate_o,
  output logic [STAT_W-1:0]             move_status_o
);

  // Gains
  logic [GAIN_W-1:0] prop_gain_q, int_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q <= GAIN_RST;
      int_gain_q  <= GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROP_GAIN: prop_gain_q <= cfg_data_i;
        CFG_INT_GAIN:  int_gain_q  <= cfg_data_i;
        default:       prop_gain_q <= prop_gain_q;
      endcase
    end
  end

  // Captured request
  logic                     op_q, stop_q;
  logic [POS_W-1:0]         goal_x_q, goal_y_q, pos_x_q, pos_y_q;
  logic signed [HEAD_W-1:0] head_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= op_i;
      stop_q   <= stop_request_i;
      goal_x_q <= goal_x_i;
      goal_y_q <= goal_y_i;
      pos_x_q  <= pos_x_i;
      pos_y_q  <= pos_y_i;
      head_q   <= heading_i;
    end
  end

  // Move state
  logic                    active_q;
  logic [POS_W-1:0]        tgt_x_q, tgt_y_q;
  logic signed [SPD_W-1:0] speed_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [TICK_W-1:0]       ticks_q;

  logic signed [DIFF_W-1:0] dx, dy;
  assign dx = $signed({1'b0, tgt_x_q}) - $signed({1'b0, pos_x_q});
  assign dy = $signed({1'b0, tgt_y_q}) - $signed({1'b0, pos_y_q});

  // Shared multiplier, one product per cycle
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W-1:0]  sum_next;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_SQX: begin
        mul_a = dx;
        mul_b = {{(MB_W-DIFF_W){dx[DIFF_W-1]}}, dx};
      end
      MUL_SQY: begin
        mul_a = dy;
        mul_b = {{(MB_W-DIFF_W){dy[DIFF_W-1]}}, dy};
      end
      MUL_PROP: begin
        mul_a = $signed({1'b0, prop_gain_q});
        mul_b = {{(MB_W-ERR_W){err[ERR_W-1]}}, err};
      end
      MUL_INT: begin
        mul_a = $signed({1'b0, int_gain_q});
        mul_b = {sum_q[SUM_W-1], sum_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Squared distance
  logic [SQ_W-1:0] sq_q, sq_sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_sq) begin
      sq_q <= prod_q[SQ_W-1:0];
    end
  end
  assign sq_sum = sq_q + prod_q[SQ_W-1:0];

  // Square root, two radicand bits per step
  logic [SQ_W-1:0]   rad_q;
  logic [DIST_W+1:0] srem_q;
  logic [DIST_W-1:0] root_q;
  logic [CNT_W-1:0]  scnt_q;
  logic [DIST_W+3:0] srem_sh, strial;

  assign srem_sh = {srem_q, rad_q[SQ_W-1 -: 2]};
  assign strial  = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scnt_q <= '0;
    end else if (cmd_i.start_sqrt) begin
      scnt_q <= CNT_W'(SQRT_STEPS);
    end else if (scnt_q != '0) begin
      scnt_q <= scnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_sqrt) begin
      rad_q  <= sq_sum;
      srem_q <= '0;
      root_q <= '0;
    end else if (scnt_q != '0) begin
      rad_q <= {rad_q[SQ_W-3:0], 2'b00};
      if (srem_sh >= strial) begin
        srem_q <= (DIST_W+2)'(srem_sh - strial);
        root_q <= {root_q[DIST_W-2:0], 1'b1};
      end else begin
        srem_q <= srem_sh[DIST_W+1:0];
        root_q <= {root_q[DIST_W-2:0], 1'b0};
      end
    end
  end

  // Bearing CORDIC, one rotation per step
  logic signed [CRD_W-1:0]  cx_q, cy_q, cx0, cy0, csx, csy;
  logic signed [CANG_W-1:0] cang_q;
  logic [3:0]               ci_q;
  logic                     cbusy_q;

  assign cx0 = CRD_W'(dx) <<< CRD_SCALE;
  assign cy0 = CRD_W'(dy) <<< CRD_SCALE;
  assign csx = cx_q >>> ci_q;
  assign csy = cy_q >>> ci_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cbusy_q <= 1'b0;
      ci_q    <= '0;
    end else if (cmd_i.start_crd) begin
      cbusy_q <= 1'b1;
      ci_q    <= '0;
    end else if (cbusy_q) begin
      ci_q <= ci_q + 1'b1;
      if (ci_q == 4'(CRD_STEPS - 1)) begin
        cbusy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_crd) begin
      // Fold the left half plane onto the right one
      if (cx0 < 0) begin
        cang_q <= (cy0 >= 0) ? PI_Q16 : -PI_Q16;
        cx_q   <= -cx0;
        cy_q   <= -cy0;
      end else begin
        cang_q <= '0;
        cx_q   <= cx0;
        cy_q   <= cy0;
      end
    end else if (cbusy_q) begin
      if (cy_q > 0) begin
        cx_q   <= cx_q + csy;
        cy_q   <= cy_q - csx;
        cang_q <= cang_q + atan_q16(ci_q);
      end else begin
        cx_q   <= cx_q - csy;
        cy_q   <= cy_q + csx;
        cang_q <= cang_q - atan_q16(ci_q);
      end
    end
  end

  // Speed target divider: dist * rate / remaining ticks
  logic [NUM_W-1:0]  dnum_q;
  logic [TICK_W-1:0] dden_q, drem_q, rem_ticks;
  logic [CNT_W-1:0]  dcnt_q;
  logic [TICK_W:0]   dtrial;

  assign rem_ticks = (ticks_q >= TICK_W'(MOVE_TICKS)) ? TICK_W'(1)
                   : TICK_W'(MOVE_TICKS) - ticks_q;
  assign dtrial = {drem_q, dnum_q[NUM_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.start_div) begin
      dcnt_q <= CNT_W'(NUM_W);
    end else if (dcnt_q != '0) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      dnum_q <= NUM_W'(root_q) * NUM_W'(TICK_RATE);
      dden_q <= rem_ticks;
      drem_q <= '0;
    end else if (dcnt_q != '0) begin
      if (dtrial >= {1'b0, dden_q}) begin
        drem_q <= TICK_W'(dtrial - {1'b0, dden_q});
        dnum_q <= {dnum_q[NUM_W-2:0], 1'b1};
      end else begin
        drem_q <= dtrial[TICK_W-1:0];
        dnum_q <= {dnum_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  // PI update
  logic [SPD_W-2:0]        target;
  logic signed [SUM_W:0]   sum_w;
  logic signed [TERM_W-1:0] pterm_q;
  logic signed [ACC_W-1:0] spd_w;
  logic signed [SPD_W-1:0] spd_sat;

  assign target = (dnum_q > NUM_W'(SPD_MAX)) ? SPD_MAX[SPD_W-2:0]
                : dnum_q[SPD_W-2:0];
  assign err    = $signed({2'b00, target}) - ERR_W'(speed_q);
  assign sum_w  = (SUM_W+1)'(sum_q) + (SUM_W+1)'(err);
  assign sum_next = (sum_w > SUM_MAX) ? SUM_MAX[SUM_W-1:0]
                  : (sum_w < SUM_MIN) ? SUM_MIN[SUM_W-1:0] : sum_w[SUM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_p) begin
      pterm_q <= prod_q[PROD_W-1:FRAC_BITS];
    end
  end

  assign spd_w = ACC_W'(speed_q) + ACC_W'(pterm_q)
               + ACC_W'($signed(prod_q[PROD_W-1:FRAC_BITS]));
  assign spd_sat = (spd_w > SPD_MAX) ? SPD_MAX[SPD_W-1:0]
                 : (spd_w < SPD_MIN) ? SPD_MIN[SPD_W-1:0] : spd_w[SPD_W-1:0];

  // Turn rate from bearing and heading
  logic signed [CANG_W-1:0] cang_r;
  logic signed [ANG_W-1:0]  brg, hw, hd, dw, turn2;
  logic signed [TURN_W-1:0] turn_sat;

  assign cang_r = (cang_q + CANG_W'(1 << (ANG_SH - 1))) >>> ANG_SH;
  assign brg = (cang_r > CANG_W'(PI_Q)) ? PI_Q
             : (cang_r < -CANG_W'(PI_Q)) ? -PI_Q : cang_r[ANG_W-1:0];
  assign hd  = ANG_W'(head_q);
  assign hw  = (hd > PI_Q) ? hd - TWO_PI_Q : (hd < -PI_Q) ? hd + TWO_PI_Q : hd;
  always_comb begin
    dw = brg - hw;
    if (dw > PI_Q) begin
      dw = dw - TWO_PI_Q;
    end else if (dw < -PI_Q) begin
      dw = dw + TWO_PI_Q;
    end
  end
  assign turn2 = dw <<< 1;
  assign turn_sat = (turn2 > ANG_W'(32767)) ? TURN_W'(32767)
                  : (turn2 < -ANG_W'(32768)) ? TURN_W'(-32768)
                  : turn2[TURN_W-1:0];

  // Move state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tgt_x_q  <= '0;
      tgt_y_q  <= '0;
      speed_q  <= '0;
      sum_q    <= '0;
      ticks_q  <= '0;
    end else begin
      if (cmd_i.load_goal) begin
        active_q <= 1'b1;
        tgt_x_q  <= goal_x_q;
        tgt_y_q  <= goal_y_q;
        speed_q  <= '0;
        sum_q    <= '0;
        ticks_q  <= '0;
      end
      if (cmd_i.clr_active) begin
        active_q <= 1'b0;
      end
      if (cmd_i.upd_sum) begin
        sum_q <= sum_next;
      end
      if (cmd_i.upd_move) begin
        speed_q <= spd_sat;
        if (ticks_q != '1) begin
          ticks_q <= ticks_q + 1'b1;
        end
      end
    end
  end

  // Result staging and output register
  logic signed [SPD_W-1:0]  res_spd_q;
  logic signed [TURN_W-1:0] res_turn_q;
  status_e                  res_stat_q;
  logic                     out_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_res) begin
      res_spd_q  <= cmd_i.res_move ? spd_sat : '0;
      res_turn_q <= cmd_i.res_move ? turn_sat : '0;
      res_stat_q <= cmd_i.res_status;
    end
    if (cmd_i.emit) begin
      linear_speed_o <= res_spd_q;
      turn_rate_o    <= res_turn_q;
      move_status_o  <= res_stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end
  assign out_valid_o = out_valid_q;

  // Status to the controller
  assign sts_o.op_start  = op_q;
  assign sts_o.active    = active_q;
  assign sts_o.root_busy = (scnt_q != '0) || cbusy_q;
  assign sts_o.arrived   = (root_q <= ARRIVE_Q);
  assign sts_o.stop      = stop_q;
  assign sts_o.div_busy  = (dcnt_q != '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scnt_q != '0) |-> !cmd_i.start_sqrt)
    else $error("square root restarted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dcnt_q != '0) |-> !cmd_i.start_div)
    else $error("divider restarted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites one not yet taken");

endmodule
`default_nettype wire

// ===== hw/rtl/go_to_goal_pi_controller_top.sv =====
// A start request or a tick without an active move passes from decode straight
// to the output state; an arrival or abort tick first waits for the 17-step
// square root, and a moving tick adds the 22-step target speed divider after
// the root.
// One request at a time: the next is taken only once the last result is emitted.
// Reset (asynchronous, active low) clears the move, gains go to 819.
`default_nettype none
// ----------------------------------------------------------------------------
// go_to_goal_pi_controller_top: go-to-goal PI speed and heading controller
// Stream in pose or start requests, stream out speed, turn rate and status.
// ----------------------------------------------------------------------------
module go_to_goal_pi_controller_top
  import gtg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [GAIN_W-1:0] cfg_data_i,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // goal_x, goal_y, pos_x, pos_y, heading, stop_request, zero fill
  input  wire logic [87:0]       s_axis_tdata,
  // op
  input  wire logic              s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // linear_speed, turn_rate, move_status, zero fill
  output logic [39:0]            m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;
  logic signed [SPD_W-1:0]  speed;
  logic signed [TURN_W-1:0] turn;
  logic [STAT_W-1:0]        status;

  gtg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gtg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (s_axis_tuser),
    .goal_x_i       (s_axis_tdata[15:0]),
    .goal_y_i       (s_axis_tdata[31:16]),
    .pos_x_i        (s_axis_tdata[47:32]),
    .pos_y_i        (s_axis_tdata[63:48]),
    .heading_i      ($signed(s_axis_tdata[79:64])),
    .stop_request_i (s_axis_tdata[80]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .linear_speed_o (speed),
    .turn_rate_o    (turn),
    .move_status_o  (status)
  );

  // Pack the result
  assign m_axis_tdata = {2'b00, status, turn, speed};

endmodule
`default_nettype wire

// ===== bench/tb_go_to_goal_pi_controller_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_go_to_goal_pi_controller_top: self-checking bench of the go-to-goal
// PI controller
// Streams start and pose requests with random gaps and checks each result
// against an in-bench fixed point model of the controller.
// ----------------------------------------------------------------------------
module tb_go_to_goal_pi_controller_top;
  import gtg_pkg::*;

  typedef struct packed {
    logic        op;
    logic [15:0] goal_x;
    logic [15:0] goal_y;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] heading;
    logic        stop;
  } req_t;

  typedef struct packed {
    logic [19:0] speed;
    logic [15:0] turn;
    status_e     status;
  } res_t;

  typedef struct packed {
    logic        is_cfg;
    logic        idx;
    logic [15:0] val;
  } cfg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [GAIN_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  go_to_goal_pi_controller_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Controller model state
  logic [15:0] m_prop = 16'd819, m_intg = 16'd819;
  logic        m_active = 1'b0;
  logic [15:0] m_tx = '0, m_ty = '0;
  longint      m_speed = 0, m_sum = 0, m_ticks = 0;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   errors = 0;
  int   n_moving = 0, n_arrived = 0, n_aborted = 0, n_idle = 0;
  longint cycles = 0;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint atan_step(int i);
    longint t[16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                      256, 128, 64, 32, 16, 8, 4, 2};
    return t[i];
  endfunction

  // CORDIC bearing in Q.16, rounded to Q.12 and clamped to +-pi
  function automatic longint bearing_q12(longint dx, longint dy);
    longint x, y, a, nx;
    x = dx * 256;
    y = dy * 256;
    a = 0;
    if (x < 0) begin
      a = (y >= 0) ? 205887 : -205887;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      if (y > 0) begin
        nx = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        a += atan_step(i);
      end else begin
        nx = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        a -= atan_step(i);
      end
      x = nx;
    end
    a = shr_floor(a + 8, 4);
    return clampl(a, -12868, 12868);
  endfunction

  function automatic longint wrap_angle(longint a);
    if (a > 12868) return a - 25736;
    if (a < -12868) return a + 25736;
    return a;
  endfunction

  // Advance the model by one request and queue its result
  task automatic predict_control(input req_t r);
    res_t   e;
    longint dx, dy, dist_q, rem, tgt, err, h;
    e = '{speed: '0, turn: '0, status: ST_MOVING};
    if (r.op) begin
      m_tx = r.goal_x;
      m_ty = r.goal_y;
      m_speed = 0;
      m_sum = 0;
      m_ticks = 0;
      m_active = 1'b1;
    end else if (!m_active) begin
      e.status = ST_IDLE;
    end else begin
      dx = longint'(m_tx) - longint'(r.pos_x);
      dy = longint'(m_ty) - longint'(r.pos_y);
      dist_q = int_sqrt(dx * dx + dy * dy);
      if (dist_q <= 410) begin
        m_active = 1'b0;
        e.status = ST_ARRIVED;
      end else if (r.stop) begin
        m_active = 1'b0;
        e.status = ST_ABORTED;
      end else begin
        rem = 100 - m_ticks;
        if (rem < 1) rem = 1;
        tgt = clampl(dist_q * 20 / rem, -524288, 524287);
        err = tgt - m_speed;
        m_sum = clampl(m_sum + err, -64'sd2147483648, 64'sd2147483647);
        m_speed = clampl(m_speed + shr_floor(longint'(m_prop) * err, 12)
                         + shr_floor(longint'(m_intg) * m_sum, 12),
                         -524288, 524287);
        h = wrap_angle(longint'($signed(r.heading)));
        e.speed = m_speed[19:0];
        e.turn = 16'(clampl(wrap_angle(bearing_q12(dx, dy) - h) * 2,
                            -32768, 32767));
        if (m_ticks < 127) m_ticks++;
      end
    end
    expected_results.push_back(e);
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(5, 80);
  endfunction

  // Driver: present requests from the queue with random gaps
  int gap_in = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_control(pending_reqs.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_in > 0 || pending_reqs.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (gap_in > 0) gap_in <= gap_in - 1;
        end else begin
          req_t n;
          n = pending_reqs[0];
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= n.op;
          s_axis_tdata <= {7'd0, n.stop, n.heading, n.pos_y, n.pos_x,
                           n.goal_y, n.goal_x};
          gap_in <= pick_gap();
        end
      end
    end
  end

  // Monitor: random stalls on the result side, compare field by field
  always @(posedge clk_i) begin
    res_t a, e;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        a.speed = m_axis_tdata[19:0];
        a.turn = m_axis_tdata[35:20];
        a.status = status_e'(m_axis_tdata[37:36]);
        if (expected_results.size() == 0) begin
          $error("result with no pending expectation: %h", m_axis_tdata);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (a.speed !== e.speed) begin
            $error("linear_speed expected %0d actual %0d",
                   $signed(e.speed), $signed(a.speed));
            errors++;
          end
          if (a.turn !== e.turn) begin
            $error("turn_rate expected %0d actual %0d",
                   $signed(e.turn), $signed(a.turn));
            errors++;
          end
          if (a.status !== e.status) begin
            $error("move_status expected %0d actual %0d", e.status, a.status);
            errors++;
          end
          case (e.status)
            ST_MOVING:  n_moving++;
            ST_ARRIVED: n_arrived++;
            ST_ABORTED: n_aborted++;
            default:    n_idle++;
          endcase
        end
      end
      m_axis_tready <= (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
    end
  end

  // Timeout guard
  always @(posedge clk_i) begin
    if (cycles > 64'd1500000) begin
      $display("go_to_goal_pi_controller_top verification failed");
      $finish;
    end
  end

  function automatic req_t start_req(logic [15:0] gx, logic [15:0] gy);
    req_t r;
    r = '0;
    r.op = 1'b1;
    r.goal_x = gx;
    r.goal_y = gy;
    r.pos_x = 16'($urandom);
    r.pos_y = 16'($urandom);
    r.heading = 16'($urandom);
    r.stop = 1'($urandom);
    return r;
  endfunction

  function automatic req_t tick_req(logic [15:0] px, logic [15:0] py,
                                    logic [15:0] hd, logic st);
    req_t r;
    r = '0;
    r.goal_x = 16'($urandom);
    r.goal_y = 16'($urandom);
    r.pos_x = px;
    r.pos_y = py;
    r.heading = hd;
    r.stop = st;
    return r;
  endfunction

  function automatic logic [15:0] rand_heading();
    return 16'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  // Wait until all results are in, then let the block settle
  task automatic drain();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_gain(logic idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PROP_GAIN) m_prop = val;
    else m_intg = val;
  endtask

  // Queue one move: start, then a walk toward the goal with random arrival and stop ticks
  task automatic queue_move(int len);
    logic [15:0] gx, gy, px, py;
    int step;
    gx = 16'($urandom);
    gy = 16'($urandom);
    pending_reqs.push_back(start_req(gx, gy));
    px = 16'($urandom);
    py = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      step = $urandom_range(0, 99);
      if (step < 4) begin
        pending_reqs.push_back(tick_req(gx + 16'($urandom_range(0, 200)) - 16'd100,
                                        gy, rand_heading(), 1'($urandom)));
      end else if (step < 7) begin
        pending_reqs.push_back(tick_req(px, py, rand_heading(), 1'b1));
      end else begin
        px = px + 16'((longint'(gx) - longint'(px)) / int'($urandom_range(2, 30)));
        py = py + 16'((longint'(gy) - longint'(py)) / int'($urandom_range(2, 30)));
        pending_reqs.push_back(tick_req(px, py, rand_heading(), 1'b0));
      end
    end
  endtask

  initial begin
    logic [15:0] gains[4] = '{16'd819, 16'd0, 16'hFFFF, 16'd4096};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: idle ticks, extremes, arrival, abort, wrap cases
    pending_reqs.push_back(tick_req(16'h0000, 16'h0000, 16'h0000, 1'b1));
    pending_reqs.push_back(start_req(16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(tick_req(16'h0000, 16'h0000, 16'sd25736, 1'b0));
    pending_reqs.push_back(tick_req(16'h0000, 16'hFFFF, -16'sd25736, 1'b0));
    pending_reqs.push_back(tick_req(16'hFFFF, 16'h0000, 16'sd12868, 1'b0));
    pending_reqs.push_back(tick_req(16'hFFFF, 16'hFE67, 16'sd0, 1'b1));
    pending_reqs.push_back(start_req(16'h0000, 16'h0000));
    pending_reqs.push_back(tick_req(16'hFFFF, 16'hFFFF, -16'sd12869, 1'b0));
    pending_reqs.push_back(tick_req(16'hFFFF, 16'h0000, 16'sd12869, 1'b0));
    pending_reqs.push_back(tick_req(16'h0000, 16'hFFFF, 16'sd0, 1'b1));
    pending_reqs.push_back(start_req(16'h8000, 16'h8000));
    pending_reqs.push_back(tick_req(16'h8000, 16'h8000 + 16'd411, 16'sd0, 1'b1));
    pending_reqs.push_back(start_req(16'h8000, 16'h8000));
    pending_reqs.push_back(tick_req(16'h8000 + 16'd410, 16'h8000, 16'sd0, 1'b1));
    pending_reqs.push_back(tick_req(16'h1234, 16'h4321, 16'sd100, 1'b1));
    pending_reqs.push_back(start_req(16'h4000, 16'h0000));
    pending_reqs.push_back(tick_req(16'h0000, 16'h0000, 16'sd0, 1'b0));
    pending_reqs.push_back(tick_req(16'h0000, 16'h8000, 16'sd0, 1'b0));
    // Run out the move time so the divisor holds at one tick
    pending_reqs.push_back(start_req(16'h2000, 16'h2000));
    for (int i = 0; i < 130; i++)
      pending_reqs.push_back(tick_req(16'h0000 + 16'(i), 16'h0000, rand_heading(), 1'b0));
    drain();

    // Random phases across several gain settings
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 4) begin
        write_gain(CFG_PROP_GAIN, gains[ph]);
        write_gain(CFG_INT_GAIN, gains[3 - ph]);
      end else begin
        write_gain(CFG_PROP_GAIN, 16'($urandom));
        write_gain(CFG_INT_GAIN, 16'($urandom));
      end
      for (int m = 0; m < 3; m++) queue_move($urandom_range(5, 30));
      for (int i = 0; i < 4; i++)
        pending_reqs.push_back(tick_req(16'($urandom), 16'($urandom),
                                        16'($urandom), 1'($urandom)));
      drain();
    end

    $display("Checked %0d moving, %0d arrived, %0d aborted and %0d idle results,",
             n_moving, n_arrived, n_aborted, n_idle);
    $display("with gains swept over zero, reset, unity and full scale.");
    if (errors == 0) begin
      $display("go_to_goal_pi_controller_top verification clean");
    end else begin
      $display("go_to_goal_pi_controller_top verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
